// File: sv/aids_pkg.sv
// Package for the array insert/delete/search block.
// Holds the sizes, operation and status codes, and the controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package aids_pkg;

   // Storage size and derived widths.
   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the request and the result.
   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 5;
   localparam int TOTAL_W  = 6;

   // Width in which a position and the count are compared.
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH   = 2'd2;
   localparam logic [OP_W-1:0] OP_TRAVERSE = 2'd3;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // latch the request and set up the walk
      logic walk;    // run the memory walk this cycle
      logic finish;  // commit the operation and load its closing result
   } aids_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done;  // no reads left and none in flight
      logic slot_free;  // result register can take a result this cycle
   } aids_stat_type;

endpackage

`default_nettype wire

// File: sv/aids_if.sv
// Request and result channel interfaces of the array insert/delete/search block.
// Depends on aids_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface aids_req_if import aids_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output operation, output position, output value,
                   input ready);
   modport sink (input valid, input operation, input position, input value,
                 output ready);
endinterface

interface aids_rsp_if import aids_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [FIDX_W-1:0]        found_index;
   logic signed [DATA_W-1:0] data;
   logic [TOTAL_W-1:0]       element_total;
   logic                     last;

   modport source (output valid, output status, output found_index, output data,
                   output element_total, output last, input ready);
   modport sink (input valid, input status, input found_index, input data,
                 input element_total, input last, output ready);
endinterface

`default_nettype wire

// File: sv/aids_ctrl.sv
// Controller state machine of the array insert/delete/search block.
// Depends on aids_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module aids_ctrl import aids_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  aids_stat_type stat,
   output aids_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // A new request is taken only between operations.
   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.walk   = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/aids_dp.sv
// Datapath of the array insert/delete/search block: element memory, count,
// walk pointer and the result register. Depends on aids_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aids_dp import aids_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  aids_cmd_type             cmd,
   output aids_stat_type            stat,
   input  logic [OP_W-1:0]          req_operation,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [FIDX_W-1:0]        rsp_found_index,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [TOTAL_W-1:0]       rsp_element_total,
   output logic                     rsp_last
);

   // Element memory and its registered read data.
   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   // Latched request.
   logic [OP_W-1:0]     op_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [DATA_W-1:0]   val_ff;
   logic [STATUS_W-1:0] code_ff;
   logic [IDX_W-1:0]    hit_idx_ff;

   // Element count and walk control.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] left_ff;
   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] pidx_ff;
   logic             pend_ff;

   // Result register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FIDX_W-1:0]   rsp_index_ff;
   logic [DATA_W-1:0]   rsp_data_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff;

   // Setup values computed from the incoming request.
   logic [CMP_W-1:0]    pos_x;
   logic [CMP_W-1:0]    cnt_x;
   logic [CMP_W-1:0]    pos_p1;
   logic [CNT_W-1:0]    cnt_m1;
   logic                full;
   logic [STATUS_W-1:0] code_in;
   logic [CNT_W-1:0]    left_in;
   logic [IDX_W-1:0]    ptr_in;

   // Walk and commit control.
   logic             is_trav;
   logic             is_shift_op;
   logic             op_ok;
   logic             slot_free;
   logic             consume;
   logic             match;
   logic             issue;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [DATA_W-1:0] mem_wd;
   logic [CNT_W-1:0] count_new;
   logic             single_out;

   assign pos_x  = CMP_W'(req_position);
   assign cnt_x  = CMP_W'(count_ff);
   assign pos_p1 = pos_x + CMP_W'(1);
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign full   = (count_ff == CNT_W'(CAPACITY));

   // Check the request against the count and set up the walk.
   always_comb begin
      code_in = ST_OK;
      left_in = '0;
      ptr_in  = '0;
      case (req_operation)
         OP_INSERT: begin
            if (pos_x > cnt_x) begin
               code_in = ST_BADPOS;
            end else if (full) begin
               code_in = ST_FULL;
            end else begin
               // Entries from position up to count-1 move up, top one first.
               left_in = count_ff - CNT_W'(req_position);
               ptr_in  = cnt_m1[IDX_W-1:0];
            end
         end
         OP_DELETE: begin
            if (pos_x >= cnt_x) begin
               code_in = ST_BADPOS;
            end else begin
               // Entries above position move down, lowest one first.
               left_in = cnt_m1 - CNT_W'(req_position);
               ptr_in  = pos_p1[IDX_W-1:0];
            end
         end
         OP_SEARCH: begin
            code_in = ST_NOTFOUND;
            left_in = count_ff;
         end
         default: begin
            code_in = (count_ff == '0) ? ST_EMPTY : ST_OK;
            left_in = count_ff;
         end
      endcase
   end

   assign is_trav     = (op_ff == OP_TRAVERSE);
   assign is_shift_op = (op_ff == OP_INSERT) || (op_ff == OP_DELETE);
   assign op_ok       = (code_ff == ST_OK);
   assign slot_free   = !rsp_valid_ff || rsp_ready;

   // A pending read is used when its consumer can take it; a traverse
   // element waits in the read register while the result side stalls.
   assign consume = cmd.walk && pend_ff && (!is_trav || slot_free);
   assign match   = consume && (op_ff == OP_SEARCH) && (rdata_ff == val_ff);
   assign issue   = cmd.walk && (left_ff != '0) && (!pend_ff || consume) && !match;

   // Memory write: shifted entries during the walk, the new value on commit.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = rdata_ff;
      if (cmd.finish) begin
         mem_we = (op_ff == OP_INSERT) && op_ok;
         mem_wa = pos_ff[IDX_W-1:0];
         mem_wd = val_ff;
      end else if (consume && is_shift_op) begin
         mem_we = 1'b1;
         mem_wa = (op_ff == OP_INSERT) ? (pidx_ff + IDX_W'(1)) : (pidx_ff - IDX_W'(1));
      end
   end

   // Element memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      if (issue) begin
         rdata_ff <= mem_ff[ptr_ff];
      end
   end

   // Count after the operation commits.
   always_comb begin
      count_new = count_ff;
      if ((op_ff == OP_INSERT) && op_ok) begin
         count_new = count_ff + CNT_W'(1);
      end else if ((op_ff == OP_DELETE) && op_ok) begin
         count_new = count_ff - CNT_W'(1);
      end
   end

   // Request latch and search hit record.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff   <= req_operation;
         pos_ff  <= req_position;
         val_ff  <= req_value;
         code_ff <= code_in;
      end else if (match) begin
         code_ff    <= ST_OK;
         hit_idx_ff <= pidx_ff;
      end
   end

   // Walk pointer; the address of the read in flight is kept in pidx_ff.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ptr_ff <= ptr_in;
      end else if (issue) begin
         pidx_ff <= ptr_ff;
         ptr_ff  <= (op_ff == OP_INSERT) ? (ptr_ff - IDX_W'(1)) : (ptr_ff + IDX_W'(1));
      end
   end

   // Walk counters and the element count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         left_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            left_ff <= left_in;
         end else if (match) begin
            left_ff <= '0;
         end else if (issue) begin
            left_ff <= left_ff - CNT_W'(1);
         end
         if (issue) begin
            pend_ff <= 1'b1;
         end else if (consume) begin
            pend_ff <= 1'b0;
         end
         if (cmd.finish) begin
            count_ff <= count_new;
         end
      end
   end

   // Every operation but a non-empty traverse closes with one result.
   assign single_out = cmd.finish && (!is_trav || (code_ff == ST_EMPTY));

   // Result register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((consume && is_trav) || single_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload.
   always_ff @(posedge clock) begin
      if (consume && is_trav) begin
         rsp_status_ff <= ST_OK;
         rsp_index_ff  <= FIDX_W'(pidx_ff);
         rsp_data_ff   <= rdata_ff;
         rsp_total_ff  <= TOTAL_W'(count_ff);
         rsp_last_ff   <= (pidx_ff == cnt_m1[IDX_W-1:0]);
      end else if (single_out) begin
         rsp_status_ff <= code_ff;
         if (is_shift_op && op_ok) begin
            rsp_index_ff <= pos_ff[FIDX_W-1:0];
         end else if ((op_ff == OP_SEARCH) && op_ok) begin
            rsp_index_ff <= FIDX_W'(hit_idx_ff);
         end else begin
            rsp_index_ff <= '0;
         end
         rsp_data_ff  <= '0;
         rsp_total_ff <= TOTAL_W'(count_new);
         rsp_last_ff  <= 1'b1;
      end
   end

   assign stat.walk_done = (left_ff == '0) && !pend_ff;
   assign stat.slot_free = slot_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found_index   = rsp_index_ff;
   assign rsp_data          = rsp_data_ff;
   assign rsp_element_total = rsp_total_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

`default_nettype wire

// File: sv/array_insert_delete_search_top.sv
// This block keeps an ordered array of up to CAPACITY signed 32-bit words and
// serves one request at a time: insert, delete, search and traverse. The element
// memory takes one registered read and one write per cycle, and each walk step
// reads one entry. An insert walks count minus position entries, and a delete
// walks the entries above the position. A search walks up to and including the
// first match, or all entries on a miss. A traverse walks all entries and gives
// one result per cycle while the result side is ready. A rejected request walks
// nothing. The closing result of a request is loaded only once the output
// register is free, so a stall on the result side holds the request back. A new
// request is taken while the previous result still waits in the output register.
// After reset the array is empty.
`timescale 1ns / 1ps
`default_nettype none

module array_insert_delete_search_top import aids_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   aids_req_if.sink   req_bus,
   aids_rsp_if.source rsp_bus
);

   aids_cmd_type  cmd;
   aids_stat_type stat;

   // Sequencing of each request.
   aids_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage, walk and result register.
   aids_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_bus.operation),
      .req_position      (req_bus.position),
      .req_value         (req_bus.value),
      .rsp_ready         (rsp_bus.ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_found_index   (rsp_bus.found_index),
      .rsp_data          (rsp_bus.data),
      .rsp_element_total (rsp_bus.element_total),
      .rsp_last          (rsp_bus.last)
   );

endmodule

`default_nettype wire
